// ===== rtl/core/plt_pkg.sv =====
// plt_pkg: shared types and codes for the peer liveness table.
// No dependencies; imported by every module of the block.
`default_nettype none
package plt_pkg;
    localparam int TIMEOUT_W = 16;
    localparam int MODE_W    = 3;
    localparam int PING_W    = 20;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 16;
    localparam int KIND_W    = 2;
    localparam int ID_W      = 4;
    localparam int ACT_W     = 5;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_PING     = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [1:0] EV_CONNECTED = 2'd0;
    localparam logic [1:0] EV_LOST      = 2'd1;
    localparam logic [1:0] EV_REPORT    = 2'd2;
    localparam logic [1:0] EV_END       = 2'd3;

    localparam logic       CFG_TIMEOUT  = 1'b0;
    localparam logic       CFG_INTERVAL = 1'b1;

    localparam logic [PING_W-1:0] MIN_SENTINEL = '1;

    // controller -> datapath
    typedef struct packed {
        logic              load_item;   // capture input item
        logic              do_register;
        logic              do_ping;
        logic              scan_peer;   // connected/lost walk for one peer
        logic              report_peer; // report walk for one peer
        logic              div_start;
        logic              clear_stats; // clear stats of reported peer
        logic              emit_scan;   // load output with scan event
        logic              emit_report;
        logic              emit_end;
        logic              cd_update;   // reload or decrement countdown
        logic [ID_W:0]     peer;
    } plt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       peer_live;
        logic       scan_event;   // scan of current peer gives an event
        logic       cd_zero;
        logic       div_done;
        logic       out_free;
    } plt_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/plt_div.sv =====
// plt_div: 32 by 16 bit restoring divider, one quotient bit per cycle.
// Depends on plt_pkg.
`default_nettype none
module plt_div
    import plt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [SUM_W-1:0]      quotient
);
    logic [5:0]       step_reg, step_next;
    logic             busy_reg, busy_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 6'd0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(SUM_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = !busy_reg && !start;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/core/plt_datapath.sv =====
// plt_datapath: peer table, statistics, countdown and output register.
// Depends on plt_pkg and plt_div.
`default_nettype none
module plt_datapath
    import plt_pkg::*;
#(
    parameter int PEERS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [TIMEOUT_W-1:0]  cfg_data,
    input  wire logic [KIND_W-1:0]     in_op,
    input  wire logic [ID_W-1:0]       in_peer,
    input  wire logic [MODE_W-1:0]     in_mode,
    input  wire logic [PING_W-1:0]     in_ping,
    input  wire plt_cmd_t              cmd,
    output plt_sts_t                   sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [KIND_W-1:0]          o_kind,
    output logic [ID_W-1:0]            o_peer,
    output logic [MODE_W-1:0]          o_mode,
    output logic [PING_W-1:0]          o_min,
    output logic [PING_W-1:0]          o_mean,
    output logic [PING_W-1:0]          o_max,
    output logic [ACT_W-1:0]           o_active
);
    localparam int PI_W = $clog2(PEERS) > 0 ? $clog2(PEERS) : 1;

    logic [TIMEOUT_W-1:0] reload_reg, interval_reg, cd_reg;
    logic [TIMEOUT_W-1:0] alive_reg [PEERS];
    logic [PEERS-1:0]     ann_reg;
    logic [MODE_W-1:0]    mode_reg  [PEERS];
    logic [PING_W-1:0]    min_reg   [PEERS];
    logic [PING_W-1:0]    max_reg   [PEERS];
    logic [SUM_W-1:0]     sum_reg   [PEERS];
    logic [CNT_W-1:0]     cnt_reg   [PEERS];
    logic [1:0]           op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [MODE_W-1:0]    md_reg;
    logic [PING_W-1:0]    ping_reg;
    logic                 ov_reg;

    logic [KIND_W-1:0]    kind_reg;
    logic [ID_W-1:0]      peer_o_reg;
    logic [MODE_W-1:0]    mode_o_reg;
    logic [PING_W-1:0]    min_o_reg, mean_o_reg, max_o_reg;
    logic [ACT_W-1:0]     act_reg;

    logic [PI_W-1:0]      p;
    logic                 id_ok;
    logic [PI_W-1:0]      ip;
    logic                 div_done;
    logic [SUM_W-1:0]     quo;
    logic [ACT_W-1:0]     active;

    assign p     = cmd.peer[PI_W-1:0];
    assign id_ok = {1'b0, id_reg} < (ID_W+1)'(PEERS);
    assign ip    = PI_W'(id_reg);

    plt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg[p]),
        .divisor  (cnt_reg[p] == '0 ? CNT_W'(1) : cnt_reg[p]),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        active = '0;
        for (int i = 0; i < PEERS; i++)
            active = active + ACT_W'(alive_reg[i] != '0);
    end

    assign sts.op         = op_reg;
    assign sts.peer_live  = alive_reg[p] != '0;
    assign sts.scan_event = (alive_reg[p] != '0) ? !ann_reg[p] : ann_reg[p];
    assign sts.cd_zero    = cd_reg == '0;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= TIMEOUT_W'(10);
            interval_reg <= TIMEOUT_W'(120);
            cd_reg       <= TIMEOUT_W'(120);
            ann_reg      <= '0;
            out_valid    <= 1'b0;
            for (int i = 0; i < PEERS; i++)
            begin
                alive_reg[i] <= '0;
                mode_reg[i]  <= '0;
                min_reg[i]   <= MIN_SENTINEL;
                max_reg[i]   <= '0;
                sum_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    reload_reg <= cfg_data;
                else
                    interval_reg <= cfg_data;
            end
            if (cmd.do_register && id_ok)
            begin
                if (md_reg != mode_reg[ip])
                    ann_reg[ip] <= 1'b0;
                mode_reg[ip]  <= md_reg;
                alive_reg[ip] <= reload_reg;
            end
            if (cmd.do_ping && id_ok)
            begin
                alive_reg[ip] <= reload_reg;
                if (ping_reg != '0)
                begin
                    if (cnt_reg[ip] != '1 && !ov_reg)
                    begin
                        cnt_reg[ip] <= cnt_reg[ip] + CNT_W'(1);
                        sum_reg[ip] <= sum_reg[ip] + SUM_W'(ping_reg);
                    end
                    if (ping_reg > max_reg[ip])
                        max_reg[ip] <= ping_reg;
                    if (ping_reg < min_reg[ip])
                        min_reg[ip] <= ping_reg;
                end
            end
            if (cmd.scan_peer)
            begin
                if (alive_reg[p] != '0)
                begin
                    ann_reg[p]   <= 1'b1;
                    alive_reg[p] <= alive_reg[p] - TIMEOUT_W'(1);
                end
                else if (ann_reg[p])
                begin
                    ann_reg[p]  <= 1'b0;
                    mode_reg[p] <= '0;
                    min_reg[p]  <= MIN_SENTINEL;
                    max_reg[p]  <= '0;
                    sum_reg[p]  <= '0;
                    cnt_reg[p]  <= '0;
                end
            end
            if (cmd.clear_stats)
            begin
                min_reg[p] <= MIN_SENTINEL;
                max_reg[p] <= '0;
                sum_reg[p] <= '0;
                cnt_reg[p] <= '0;
            end
            if (cmd.cd_update)
                cd_reg <= (cd_reg == '0 ? interval_reg : cd_reg) - TIMEOUT_W'(1);
            if (cmd.emit_scan || cmd.emit_report || cmd.emit_end)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= in_op;
            id_reg   <= in_peer;
            md_reg   <= in_mode;
            ping_reg <= in_ping;
        end
        // overflow check for the sum is registered from the input item as it is captured
        ov_reg <= ({1'b0, sum_reg[PI_W'(in_peer)]} + (SUM_W+1)'(in_ping))
                  > (SUM_W+1)'({SUM_W{1'b1}});
        if (cmd.emit_scan)
        begin
            kind_reg   <= alive_reg[p] != '0 ? EV_CONNECTED : EV_LOST;
            peer_o_reg <= ID_W'(cmd.peer);
            mode_o_reg <= alive_reg[p] != '0 ? mode_reg[p] : '0;
            min_o_reg  <= '0;
            mean_o_reg <= '0;
            max_o_reg  <= '0;
            act_reg    <= '0;
        end
        else if (cmd.emit_report)
        begin
            kind_reg   <= EV_REPORT;
            peer_o_reg <= ID_W'(cmd.peer);
            mode_o_reg <= '0;
            min_o_reg  <= min_reg[p];
            mean_o_reg <= quo[PING_W-1:0];
            max_o_reg  <= max_reg[p];
            act_reg    <= '0;
        end
        else if (cmd.emit_end)
        begin
            kind_reg   <= EV_END;
            peer_o_reg <= '0;
            mode_o_reg <= '0;
            min_o_reg  <= '0;
            mean_o_reg <= '0;
            max_o_reg  <= '0;
            act_reg    <= active;
        end
    end

    assign o_kind   = kind_reg;
    assign o_peer   = peer_o_reg;
    assign o_mode   = mode_o_reg;
    assign o_min    = min_o_reg;
    assign o_mean   = mean_o_reg;
    assign o_max    = max_o_reg;
    assign o_active = act_reg;
endmodule
`default_nettype wire

// ===== rtl/core/plt_ctrl.sv =====
// plt_ctrl: sequencer for register, ping and the tick walks.
// Depends on plt_pkg.
`default_nettype none
module plt_ctrl
    import plt_pkg::*;
#(
    parameter int PEERS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire plt_sts_t  sts,
    output plt_cmd_t       cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RPT    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_END    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [ID_W:0] peer_reg, peer_next;
    logic          rpt_reg, rpt_next;
    logic          last_peer;

    assign last_peer = peer_reg == (ID_W+1)'(PEERS - 1);
    assign in_ready  = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        peer_next  = peer_reg;
        rpt_next   = rpt_reg;
        cmd        = '0;
        cmd.peer   = peer_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                peer_next = '0;
                priority if (sts.op == OP_REGISTER)
                begin
                    cmd.do_register = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (sts.op == OP_PING)
                begin
                    cmd.do_ping = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (sts.op == OP_TICK)
                    state_next = S_SCAN;
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (!sts.scan_event || sts.out_free)
                begin
                    cmd.scan_peer = 1'b1;
                    cmd.emit_scan = sts.scan_event;
                    if (last_peer)
                    begin
                        peer_next    = '0;
                        rpt_next     = sts.cd_zero;
                        cmd.cd_update = 1'b1;
                        state_next   = sts.cd_zero ? S_RPT : S_END;
                    end
                    else
                        peer_next = peer_reg + 1'b1;
                end
            end
            S_RPT:
            begin
                if (sts.peer_live)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (last_peer)
                    state_next = S_END;
                else
                    peer_next = peer_reg + 1'b1;
            end
            S_DIV:
            begin
                if (sts.div_done && sts.out_free)
                begin
                    cmd.emit_report = 1'b1;
                    cmd.clear_stats = 1'b1;
                    if (last_peer)
                        state_next = S_END;
                    else
                    begin
                        peer_next  = peer_reg + 1'b1;
                        state_next = S_RPT;
                    end
                end
            end
            S_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            peer_reg  <= '0;
            rpt_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            peer_reg  <= peer_next;
            rpt_reg   <= rpt_next;
        end
    end

    a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_scan, cmd.emit_report, cmd.emit_end}))
        else $error("two result loads at once");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");
    a_report_marked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rpt_reg)
        else $error("report outside a report tick");
    a_peer_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && state_reg != S_DECODE |-> peer_reg < (ID_W+1)'(PEERS))
        else $error("peer index out of range");
endmodule
`default_nettype wire

// ===== rtl/core/peer_liveness_table_unit.sv =====
// peer_liveness_table_unit: top level of the peer liveness table.
// Depends on plt_pkg, plt_ctrl, plt_datapath (and plt_div below it).
//
//  channel  | dir | tdata fields (low bit first)                          | tuser
//  s_axis   | in  | operation[1:0] peer_id[5:2] peer_mode[8:6] ping_us[28:9] | -
//  m_axis   | out | event_peer, event_mode, ping_min, ping_mean, ping_max,    | event_kind
//           |     | active_count                                         | tlast=last
//  cfg      | in  | index 0 timeout_reload, 1 stat_interval               | -
//
// Register and ping pass from idle through decode. A tick walks every peer in turn;
// a report tick walks them again and runs the bit-serial 32-bit divider per live peer.
// Reset: table cleared, timeout_reload 10, stat_interval 120.
// A stalled m_axis holds the walk; one result waits in the output register.
`default_nettype none
module peer_liveness_table_unit
    import plt_pkg::*;
#(
    parameter int PEERS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // operation, peer_id, peer_mode, ping_us
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // peer, mode, min, mean, max, active_count
    output logic [1:0]       m_axis_tuser,   // event_kind
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    plt_cmd_t         cmd;
    plt_sts_t         sts;
    logic [ID_W-1:0]  o_peer;
    logic [MODE_W-1:0] o_mode;
    logic [PING_W-1:0] o_min, o_mean, o_max;
    logic [ACT_W-1:0] o_active;

    plt_ctrl #(.PEERS(PEERS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .sts(sts), .cmd(cmd)
    );

    plt_datapath #(.PEERS(PEERS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_op(s_axis_tdata[1:0]), .in_peer(s_axis_tdata[5:2]),
        .in_mode(s_axis_tdata[8:6]), .in_ping(s_axis_tdata[28:9]),
        .cmd(cmd), .sts(sts),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_peer(o_peer), .o_mode(o_mode),
        .o_min(o_min), .o_mean(o_mean), .o_max(o_max), .o_active(o_active)
    );

    assign m_axis_tdata = {o_active, o_max, o_mean, o_min, o_mode, o_peer};
    assign m_axis_tlast = m_axis_tuser == EV_END;
endmodule
`default_nettype wire
